>>> sv/assert_macros.svh
// assertion macros used by bnbc_back
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/bnbc_pkg.sv
// types, constants and saturating add for the naive bayes classifier
// no dependencies
package bnbc_pkg;

  localparam int FUNC_W      = 2;
  localparam int CLS_W       = 4;
  localparam int PIX_W       = 10;
  localparam int LIK_W       = 13;
  localparam int PAIR_W      = 2 * LIK_W;
  localparam int SCORE_W     = 24;
  localparam int NCLS_W      = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX     = 24'sh7fffff;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN     = 24'sh800000;
  localparam logic signed [SCORE_W-1:0] THRESH_RESET  = -24'sd102400;
  localparam logic [NCLS_W-1:0]         CLASSES_RESET = 5'd10;

  typedef enum logic [1:0] {
    CMD_PAIR  = 2'd0,
    CMD_PRIOR = 2'd1,
    CMD_PIXEL = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [CLS_W-1:0]        class_index;
    logic [PIX_W-1:0]        pixel_index;
    logic signed [LIK_W-1:0] log_if_zero;
    logic signed [LIK_W-1:0] log_if_one;
    logic signed [LIK_W-1:0] prior_log;
    logic                    pixel_value;
    logic                    last_pixel;
    logic                    pix_ok;
  } cmd_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] threshold;
    logic [NCLS_W-1:0]         classes;
  } cfg_t;

  typedef struct packed {
    logic [CLS_W-1:0]          best_class;
    logic                      rejected;
    logic signed [SCORE_W-1:0] best_score;
  } result_t;

  function automatic logic signed [SCORE_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [LIK_W-1:0]   b
  );
    logic signed [SCORE_W:0] s;
    s = (SCORE_W+1)'(a) + (SCORE_W+1)'(b);
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end
    return s[SCORE_W-1:0];
  endfunction

endpackage

>>> sv/bnbc_if.sv
// input and result channel interfaces of the classifier
// depends on bnbc_pkg for field widths
interface bnbc_in_if;
  logic                              valid;
  logic                              ready;
  logic [bnbc_pkg::FUNC_W-1:0]       func;
  logic [bnbc_pkg::CLS_W-1:0]        class_index;
  logic [bnbc_pkg::PIX_W-1:0]        pixel_index;
  logic signed [bnbc_pkg::LIK_W-1:0] log_if_zero;
  logic signed [bnbc_pkg::LIK_W-1:0] log_if_one;
  logic signed [bnbc_pkg::LIK_W-1:0] prior_log;
  logic                              pixel_value;
  logic                              last_pixel;

  modport source (
    output valid, func, class_index, pixel_index, log_if_zero, log_if_one,
           prior_log, pixel_value, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, func, class_index, pixel_index, log_if_zero, log_if_one,
           prior_log, pixel_value, last_pixel,
    output ready
  );
endinterface

interface bnbc_out_if;
  logic                                valid;
  logic                                ready;
  logic [bnbc_pkg::CLS_W-1:0]          best_class;
  logic                                rejected;
  logic signed [bnbc_pkg::SCORE_W-1:0] best_score;

  modport source (output valid, best_class, rejected, best_score, input ready);
  modport sink (input valid, best_class, rejected, best_score, output ready);
endinterface

>>> sv/bnbc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module bnbc_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> sv/bnbc_front.sv
// front end: accepts input words, decodes func, drops ignored words, queues commands
// depends on bnbc_pkg and bnbc_if
module bnbc_front #(
  parameter int MAX_CLASSES = 16,
  parameter int MAX_PIXELS  = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  bnbc_in_if.sink        in_ch,
  output bnbc_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_pop
);
  import bnbc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [FUNC_W-1:0] FUNC_PAIR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PRIOR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd2;

  cmd_t          q_r [QUEUE_DEPTH];
  cmd_t          dec;
  logic          keep, cls_ok, pix_ok, push, pop;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  always_comb begin
    cls_ok = 32'(in_ch.class_index) < MAX_CLASSES;
    pix_ok = 32'(in_ch.pixel_index) < MAX_PIXELS;
    dec.kind        = CMD_PIXEL;
    dec.class_index = in_ch.class_index;
    dec.pixel_index = in_ch.pixel_index;
    dec.log_if_zero = in_ch.log_if_zero;
    dec.log_if_one  = in_ch.log_if_one;
    dec.prior_log   = in_ch.prior_log;
    dec.pixel_value = in_ch.pixel_value;
    dec.last_pixel  = in_ch.last_pixel;
    dec.pix_ok      = pix_ok;
    unique case (in_ch.func)
      FUNC_PAIR: begin
        dec.kind = CMD_PAIR;
        keep     = cls_ok && pix_ok;
      end
      FUNC_PRIOR: begin
        dec.kind = CMD_PRIOR;
        keep     = cls_ok;
      end
      FUNC_PIXEL: begin
        dec.kind = CMD_PIXEL;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = count_r != (PW+1)'(QUEUE_DEPTH);
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign cmd_valid   = count_r != '0;
  assign pop         = cmd_valid && cmd_pop;
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end
endmodule

>>> sv/bnbc_back.sv
// back end: likelihood lanes, class accumulators, sequential argmax and result register
// depends on bnbc_pkg, bnbc_if, bnbc_ram and assert_macros.svh
`include "assert_macros.svh"

module bnbc_back #(
  parameter int MAX_CLASSES = 16,
  parameter int MAX_PIXELS  = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bnbc_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  bnbc_pkg::cfg_t cfg,
  bnbc_out_if.source     out_ch
);
  import bnbc_pkg::*;

  localparam int AW  = $clog2(MAX_PIXELS);
  localparam int CIW = $clog2(MAX_CLASSES);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_WAIT = 3'b010,
    ST_DEC  = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [AW-1:0]             addr;
  logic [PAIR_W-1:0]         rd [MAX_CLASSES];
  logic signed [LIK_W-1:0]   prior_r [MAX_CLASSES];
  logic signed [SCORE_W-1:0] acc_r [MAX_CLASSES];
  logic signed [SCORE_W-1:0] acc_nxt [MAX_CLASSES];
  logic                      pend_r, pend_nxt, pval_r;
  logic                      pop_pair, pop_prior, pop_last;
  logic [CIW-1:0]            idx_r, idx_nxt, last_idx, best_idx_r, best_idx_nxt;
  logic signed [SCORE_W-1:0] best_score_r, best_score_nxt, s_dec;
  logic                      take, at_last, out_free, out_load;
  logic                      out_valid_r, out_valid_nxt;
  result_t                   res_r;

  assign cmd_pop   = cmd_valid && (state_r == ST_RUN);
  assign pop_pair  = cmd_pop && (cmd.kind == CMD_PAIR);
  assign pop_prior = cmd_pop && (cmd.kind == CMD_PRIOR);
  assign pop_last  = cmd_pop && (cmd.kind == CMD_PIXEL) && cmd.last_pixel;
  assign pend_nxt  = cmd_pop && (cmd.kind == CMD_PIXEL) && cmd.pix_ok;
  assign addr      = AW'(cmd.pixel_index);

  for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_lane
    logic lane_sel;
    assign lane_sel = 32'(cmd.class_index) == g;

    bnbc_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_PIXELS)) u_ram (
      .clk   (clk),
      .we    (pop_pair && lane_sel),
      .waddr (addr),
      .wdata ({cmd.log_if_one, cmd.log_if_zero}),
      .raddr (addr),
      .rdata (rd[g])
    );

    always_ff @(posedge clk) begin
      if (pop_prior && lane_sel) begin
        prior_r[g] <= cmd.prior_log;
      end
    end

    always_comb begin
      if (out_load) begin
        acc_nxt[g] = '0;
      end else if (pend_r) begin
        acc_nxt[g] = sat_add(acc_r[g], pval_r ? $signed(rd[g][PAIR_W-1:LIK_W])
                                              : $signed(rd[g][LIK_W-1:0]));
      end else begin
        acc_nxt[g] = acc_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r[g] <= '0;
      end else begin
        acc_r[g] <= acc_nxt[g];
      end
    end
  end

  always_comb begin
    priority if (cfg.classes == '0) begin
      last_idx = '0;
    end else if (32'(cfg.classes) > MAX_CLASSES) begin
      last_idx = CIW'(MAX_CLASSES - 1);
    end else begin
      last_idx = CIW'(cfg.classes - 1'b1);
    end
  end

  assign s_dec    = sat_add(acc_r[idx_r], prior_r[idx_r]);
  assign take     = (idx_r == '0) || (s_dec > best_score_r);
  assign at_last  = idx_r == last_idx;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == ST_DEC) && at_last && out_free;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    best_idx_nxt   = best_idx_r;
    best_score_nxt = best_score_r;
    unique case (state_r)
      ST_RUN: begin
        if (pop_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_DEC;
        idx_nxt   = '0;
      end
      ST_DEC: begin
        if (take) begin
          best_idx_nxt   = idx_r;
          best_score_nxt = s_dec;
        end
        if (at_last) begin
          if (out_free) begin
            state_nxt = ST_RUN;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pval_r       <= cmd.pixel_value;
    best_idx_r   <= best_idx_nxt;
    best_score_r <= best_score_nxt;
    if (out_load) begin
      res_r.best_class <= CLS_W'(best_idx_nxt);
      res_r.rejected   <= best_score_nxt < cfg.threshold;
      res_r.best_score <= best_score_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.best_class = res_r.best_class;
  assign out_ch.rejected   = res_r.rejected;
  assign out_ch.best_score = res_r.best_score;

  `ASSERT_NEXT(a_last_to_wait, clk, rst_n, pop_last, state_r == ST_WAIT)
  `ASSERT_CHK(a_no_add_in_dec, clk, rst_n, (state_r == ST_DEC) |-> !pend_r)
  `ASSERT_CHK(a_idx_in_range, clk, rst_n, (state_r == ST_DEC) |-> (idx_r <= last_idx))
  `ASSERT_NEXT(a_clear_on_out, clk, rst_n, out_load, (acc_r[0] == '0) && out_valid_r)
endmodule

>>> sv/bernoulli_naive_bayes_classifier_unit.sv
// top level of the bernoulli naive bayes classifier: register port, front and back ends
// depends on bnbc_pkg, bnbc_if, bnbc_front and bnbc_back
//
// Classifies binary images against up to MAX_CLASSES classes of MAX_PIXELS pixels using
// host-loaded Q.8 log likelihood pairs (one RAM lane per class) and log priors. Table
// writes and image pixels are taken one word per cycle into a four-entry command queue
// while it has room; the back end drains it at one word per cycle, every class
// accumulator adding its saturated likelihood in parallel in the cycle after the lane
// read. On the last pixel the back end pauses the queue (classes_in_use taken as 1 when
// zero and as MAX_CLASSES when larger): first a wait state to finish the last add, then
// one accumulator-plus-prior compare per class in use, lowest class winning ties. The last
// compare is held while the previous result still waits in the output register; once
// loaded, the result sits there while new words keep flowing. Tables are not cleared by
// reset and must be written before use; registers sit at 0x0 (reject threshold) and 0x4
// (classes in use) and should only be written while the block is idle.
module bernoulli_naive_bayes_classifier_unit #(
  parameter int MAX_CLASSES = 16,
  parameter int MAX_PIXELS  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  bnbc_in_if.sink     in_ch,
  bnbc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bnbc_pkg::*;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_CLASSES   = 1'b1;

  logic signed [SCORE_W-1:0] thr_r, thr_nxt;
  logic [NCLS_W-1:0]         ncls_r, ncls_nxt;
  logic                      wr_en;
  cfg_t                      cfg;
  cmd_t                      cmd;
  logic                      cmd_valid, cmd_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    thr_nxt  = thr_r;
    ncls_nxt = ncls_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_THRESHOLD: thr_nxt  = pwdata[SCORE_W-1:0];
        REG_CLASSES:   ncls_nxt = pwdata[NCLS_W-1:0];
        default:       thr_nxt  = thr_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {{(32-SCORE_W){thr_r[SCORE_W-1]}}, thr_r};
      REG_CLASSES:   prdata = {{(32-NCLS_W){1'b0}}, ncls_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESH_RESET;
      ncls_r <= CLASSES_RESET;
    end else begin
      thr_r  <= thr_nxt;
      ncls_r <= ncls_nxt;
    end
  end

  assign cfg.threshold = thr_r;
  assign cfg.classes   = ncls_r;

  bnbc_front #(.MAX_CLASSES(MAX_CLASSES), .MAX_PIXELS(MAX_PIXELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  bnbc_back #(.MAX_CLASSES(MAX_CLASSES), .MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg),
    .out_ch    (out_ch)
  );
endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// testbench for bernoulli_naive_bayes_classifier_unit: table loads, images and register
// settings are streamed in; decisions are checked against an in-bench scorer and typed
// rows against their verdict; depends on bnbc_pkg, bnbc_if and the classifier rtl
module tb;
  import bnbc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE     = 2'd3;
  localparam logic [2:0]        REG_THRESHOLD = 3'h0;
  localparam logic [2:0]        REG_CLASSES   = 3'h4;
  localparam int NUM_CLASSES   = 16;
  localparam int NUM_PIXELS    = 1024;
  localparam int SETTLE_CYCLES = 40;
  localparam int DEEP_PIXELS   = 200;
  localparam int PHASE_WORDS   = 100;
  localparam int NUM_PHASES    = 8;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic [CLS_W-1:0]        cls;
    logic [PIX_W-1:0]        pix;
    logic signed [LIK_W-1:0] lz;
    logic signed [LIK_W-1:0] lo;
    logic signed [LIK_W-1:0] pr;
    logic                    pv;
    logic                    lp;
  } bus_word_t;

  typedef struct {
    bus_word_t w;
    bit        typed;
    result_t   want;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bnbc_in_if  in_if ();
  bnbc_out_if out_if ();

  bernoulli_naive_bayes_classifier_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // scorer state
  logic signed [LIK_W-1:0] mirror_if_zero [NUM_CLASSES][NUM_PIXELS];
  logic signed [LIK_W-1:0] mirror_if_one  [NUM_CLASSES][NUM_PIXELS];
  logic signed [LIK_W-1:0] mirror_prior   [NUM_CLASSES];
  int                      running_score  [NUM_CLASSES];
  int                      cfg_threshold;
  logic [NCLS_W-1:0]       cfg_classes;

  result_t expected_verdicts [$];

  // directed stimulus table
  table_row_t rows [$];

  // which class entries of each pixel are loaded
  logic [NUM_CLASSES-1:0] pair_written [NUM_PIXELS];
  bit                     pixel_listed [NUM_PIXELS];
  int                     ready_pixels [$];

  int mismatches;
  int words_sent;
  int images_sent;
  int rejects_seen;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("bernoulli_naive_bayes_classifier_unit verification failed");
    $finish;
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic int clamp_score(input longint s);
    if (s > longint'(SCORE_MAX)) return int'(SCORE_MAX);
    if (s < longint'(SCORE_MIN)) return int'(SCORE_MIN);
    return int'(s);
  endfunction

  task automatic classify_word(input bus_word_t w, output bit produced, output result_t v);
    int add;
    int n;
    int best;
    int top;
    int s;
    produced = 1'b0;
    v = '0;
    if (w.func == CMD_PAIR) begin
      mirror_if_zero[w.cls][w.pix] = w.lz;
      mirror_if_one[w.cls][w.pix] = w.lo;
    end else if (w.func == CMD_PRIOR) begin
      mirror_prior[w.cls] = w.pr;
    end else if (w.func == CMD_PIXEL) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        add = w.pv ? int'(mirror_if_one[c][w.pix]) : int'(mirror_if_zero[c][w.pix]);
        running_score[c] = clamp_score(longint'(running_score[c]) + longint'(add));
      end
      if (w.lp) begin
        n = int'(cfg_classes);
        if (n == 0) n = 1;
        if (n > NUM_CLASSES) n = NUM_CLASSES;
        best = 0;
        add = int'(mirror_prior[0]);
        top = clamp_score(longint'(running_score[0]) + longint'(add));
        for (int c = 1; c < n; c++) begin
          add = int'(mirror_prior[c]);
          s = clamp_score(longint'(running_score[c]) + longint'(add));
          if (s > top) begin
            top = s;
            best = c;
          end
        end
        v.best_class = best[CLS_W-1:0];
        v.rejected = (top < cfg_threshold);
        v.best_score = top[SCORE_W-1:0];
        produced = 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) running_score[c] = 0;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 25) begin
      burst_left = $urandom_range(40, 150);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 900) return $urandom_range(1, 3);
    if (r < 980) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [LIK_W-1:0] rand_log();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r == 0) v = -4096;
    else if (r == 1) v = 0;
    else if (r == 2) v = -256;
    else v = -int'($urandom_range(0, 4096));
    return LIK_W'(v);
  endfunction

  function automatic bus_word_t random_word(input logic [FUNC_W-1:0] func);
    bus_word_t w;
    w.func = func;
    w.cls = CLS_W'($urandom_range(0, NUM_CLASSES - 1));
    w.pix = PIX_W'($urandom_range(0, NUM_PIXELS - 1));
    w.lz = rand_log();
    w.lo = rand_log();
    w.pr = rand_log();
    w.pv = 1'($urandom_range(0, 1));
    w.lp = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic queue_row(input logic [FUNC_W-1:0] func, input int cls, input int pix,
                           input int lz, input int lo, input int pr, input bit pv,
                           input bit lp, input bit typed, input int bc, input bit rj,
                           input int sc);
    table_row_t r;
    r.w.func = func;
    r.w.cls = CLS_W'(cls);
    r.w.pix = PIX_W'(pix);
    r.w.lz = LIK_W'(lz);
    r.w.lo = LIK_W'(lo);
    r.w.pr = LIK_W'(pr);
    r.w.pv = pv;
    r.w.lp = lp;
    r.typed = typed;
    r.want.best_class = CLS_W'(bc);
    r.want.rejected = rj;
    r.want.best_score = SCORE_W'(sc);
    rows.insert(rows.size(), r);
  endtask

  // entered and left at a falling edge
  task automatic push_word(input bus_word_t w, input bit typed = 1'b0,
                           input result_t want = '0);
    int gap;
    bit produced;
    result_t v;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.func <= w.func;
    in_if.class_index <= w.cls;
    in_if.pixel_index <= w.pix;
    in_if.log_if_zero <= w.lz;
    in_if.log_if_one <= w.lo;
    in_if.prior_log <= w.pr;
    in_if.pixel_value <= w.pv;
    in_if.last_pixel <= w.lp;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    classify_word(w, produced, v);
    if (produced) begin
      if (typed) v = want;
      expected_verdicts.insert(expected_verdicts.size(), v);
      images_sent++;
      if (v.rejected) rejects_seen++;
    end
    if (w.func != FUNC_NONE) words_sent++;
    if (w.func == CMD_PAIR) begin
      pair_written[w.pix][w.cls] = 1'b1;
      if (&pair_written[w.pix] && !pixel_listed[w.pix]) begin
        pixel_listed[w.pix] = 1'b1;
        ready_pixels.insert(ready_pixels.size(), int'(w.pix));
      end
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    logic signed [SCORE_W-1:0] t;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_THRESHOLD) begin
      t = data[SCORE_W-1:0];
      cfg_threshold = int'(t);
    end else if (addr == REG_CLASSES) begin
      cfg_classes = data[NCLS_W-1:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_check(input logic [2:0] addr, input logic [31:0] want,
                           input logic [31:0] mask);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != (want & mask)) begin
      report($sformatf("register 0x%0h read 0x%0h, expected 0x%0h", addr,
                       prdata & mask, want & mask));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input int thr, input int ncls);
    reg_write(REG_THRESHOLD, 32'(thr));
    reg_write(REG_CLASSES, 32'(ncls));
    reg_check(REG_THRESHOLD, 32'(thr), 32'hFF_FFFF);
    reg_check(REG_CLASSES, 32'(ncls), 32'h1F);
  endtask

  task automatic fill_pixel(input int p, input bit scramble, input int value);
    bus_word_t w;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      w = random_word(CMD_PAIR);
      w.cls = CLS_W'(c);
      w.pix = PIX_W'(p);
      if (!scramble) begin
        w.lz = LIK_W'(value);
        w.lo = LIK_W'(value);
      end
      push_word(w);
    end
  endtask

  task automatic load_priors(input int value);
    bus_word_t w;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      w = random_word(CMD_PRIOR);
      w.cls = CLS_W'(c);
      w.pr = LIK_W'(value);
      push_word(w);
    end
  endtask

  task automatic send_image(input int len);
    bus_word_t w;
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) push_word(random_word(CMD_PAIR));
      else if (r < 10) push_word(random_word(CMD_PRIOR));
      else if (r < 13) push_word(random_word(FUNC_NONE));
      w = random_word(CMD_PIXEL);
      w.pix = PIX_W'(ready_pixels[$urandom_range(0, ready_pixels.size() - 1)]);
      w.lp = (i == len - 1);
      push_word(w);
    end
  endtask

  task automatic run_random(input int quota);
    int start;
    int r;
    int len;
    start = words_sent;
    while (words_sent - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 8);
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(31, 80);
        else len = $urandom_range(9, 30);
        send_image(len);
      end else if (r < 70) begin
        fill_pixel(int'($urandom_range(0, NUM_PIXELS - 1)), 1'b1, 0);
      end else if (r < 82) begin
        push_word(random_word(CMD_PAIR));
      end else if (r < 92) begin
        push_word(random_word(CMD_PRIOR));
      end else begin
        push_word(random_word(FUNC_NONE));
      end
    end
  endtask

  // result side
  initial begin
    int run;
    int stall;
    int roll;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      roll = $urandom_range(0, 99);
      run = (roll < 5) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (run) begin
        @(negedge clk);
        out_if.ready <= 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) stall = $urandom_range(1, 3);
      else if (roll < 97) stall = $urandom_range(4, 10);
      else stall = $urandom_range(20, 40);
      repeat (stall) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        report($sformatf("unexpected result class %0d rejected %0b score %0d",
                         out_if.best_class, out_if.rejected, out_if.best_score));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_if.best_class !== want.best_class || out_if.rejected !== want.rejected ||
            out_if.best_score !== want.best_score) begin
          report($sformatf("result class %0d rejected %0b score %0d, expected %0d %0b %0d",
                           out_if.best_class, out_if.rejected, out_if.best_score,
                           want.best_class, want.rejected, want.best_score));
        end
      end
    end
  end

  initial begin
    bus_word_t w;
    int thr;
    int ncls;
    int waited;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.func = '0;
    in_if.class_index = '0;
    in_if.pixel_index = '0;
    in_if.log_if_zero = '0;
    in_if.log_if_one = '0;
    in_if.prior_log = '0;
    in_if.pixel_value = 1'b0;
    in_if.last_pixel = 1'b0;
    cfg_threshold = int'(THRESH_RESET);
    cfg_classes = CLASSES_RESET;
    for (int c = 0; c < NUM_CLASSES; c++) running_score[c] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    reg_check(REG_THRESHOLD, 32'(int'(THRESH_RESET)), 32'hFF_FFFF);
    reg_check(REG_CLASSES, 32'(CLASSES_RESET), 32'h1F);

    // zero priors, zero pairs at the first and last pixel
    load_priors(0);
    fill_pixel(0, 1'b0, 0);
    fill_pixel(NUM_PIXELS - 1, 1'b0, 0);

    queue_row(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
    queue_row(CMD_PRIOR, 0, 0, 0, 0, -4096, 0, 0, 0, 0, 0, 0);
    queue_row(CMD_PRIOR, 15, 1023, 0, 0, -4096, 1, 1, 0, 0, 0, 0);
    queue_row(CMD_PAIR, 3, 1023, -4096, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_row(CMD_PAIR, 15, 1023, 0, -4096, 0, 0, 0, 0, 0, 0, 0);
    queue_row(CMD_PIXEL, 0, 1023, 0, 0, 0, 1, 1, 1, 1, 0, 0);
    queue_row(FUNC_NONE, 15, 1023, -1, -1, -1, 1, 1, 0, 0, 0, 0);
    queue_row(CMD_PIXEL, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_row(CMD_PRIOR, 1, 0, 0, 0, -4096, 0, 0, 0, 0, 0, 0);
    queue_row(CMD_PIXEL, 0, 0, 0, 0, 0, 1, 1, 1, 2, 0, 0);
    queue_row(CMD_PAIR, 8, 'h2AA, -1, -4096, -1, 1, 1, 0, 0, 0, 0);
    queue_row(CMD_PAIR, 7, 'h155, -4096, -1, -4096, 0, 0, 0, 0, 0, 0);
    queue_row(CMD_PRIOR, 2, 0, 0, 0, -1, 0, 0, 0, 0, 0, 0);
    queue_row(CMD_PIXEL, 5, 1023, -4096, -4096, -4096, 0, 1, 0, 0, 0, 0);
    queue_row(FUNC_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    foreach (rows[i]) push_word(rows[i].w, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      thr = -int'($urandom_range(2000, 40000));
      ncls = $urandom_range(2, NUM_CLASSES - 1);
      case (ph)
        0: begin
          thr = 0;
          ncls = NUM_CLASSES;
        end
        1: begin
          thr = int'(SCORE_MIN);
          ncls = 1;
        end
        2: ncls = 0;
        3: ncls = 31;
        5: ncls = NUM_CLASSES + 1;
        7: begin
          thr = int'(THRESH_RESET);
          ncls = int'(CLASSES_RESET);
        end
        default: ;
      endcase
      set_config(thr, ncls);
      run_random(PHASE_WORDS);
    end

    // one long image with every class tied far below zero
    drain();
    set_config(int'(SCORE_MIN), NUM_CLASSES);
    fill_pixel(NUM_PIXELS - 1, 1'b0, -4096);
    load_priors(-4096);
    for (int i = 0; i < DEEP_PIXELS; i++) begin
      w = random_word(CMD_PIXEL);
      w.pix = PIX_W'(NUM_PIXELS - 1);
      w.lp = (i == DEEP_PIXELS - 1);
      push_word(w);
    end

    in_if.valid <= 1'b0;
    waited = 0;
    while (expected_verdicts.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_verdicts.size() != 0) begin
      report($sformatf("%0d results never arrived", expected_verdicts.size()));
    end

    $display("run covered %0d table and pixel words, %0d images (%0d rejected)",
             words_sent, images_sent, rejects_seen);
    $display("over %0d register settings, ending with one long fully tied image",
             NUM_PHASES + 1);
    if (mismatches == 0) begin
      $display("bernoulli_naive_bayes_classifier_unit verification clean");
    end else begin
      $display("bernoulli_naive_bayes_classifier_unit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/bnbc_pkg.sv
sv/bnbc_if.sv
sv/bnbc_ram.sv
sv/bnbc_front.sv
sv/bnbc_back.sv
sv/bernoulli_naive_bayes_classifier_unit.sv
test/tb.sv
